// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mi_pkg.sv -----
// ----------------------------------------------------------------------------
// mi_pkg
// Shared widths, microcode types and status bundle for the modular inverse.
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam int WIDTH     = 16;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int UPC_W     = 3;
  localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(256);

  // Datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,      // capture value, start value mod n
    OP_DIVSTEP,   // one restoring divide bit plus one modular multiply bit
    OP_SETRC,     // r_cur <= value mod n
    OP_DIVSETUP,  // divide r_prev by r_cur
    OP_UPDATE,    // shift the remainder and coefficient pairs
    OP_FINISH     // drive the result word
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IDLE,    // no start request
    COND_CNT,     // bit counter not yet zero
    COND_RCLE1,   // remainder reached 1 or 0
    COND_NLT2     // modulus is 0 or 1
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic cnt_nz;
    logic rc_le1;
    logic n_lt2;
  } status_t;

endpackage

// ----- design/modular_inverse_unit.sv -----
// ----------------------------------------------------------------------------
// modular_inverse_unit
// Inverse of a value modulo a programmable modulus by the extended Euclidean
// recurrence, run by a small microprogram over a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------
//  config   | cfg_we_i, cfg_data_i             | write when cfg_we_i high
//  request  | start, value_i, busy             | taken when start && !busy
//  result   | done_o, inverse_o, no_inverse_o  | one-cycle strobe on done_o
//
// The result strobe comes after k Euclid quotient steps from the accepting
// edge (k at most 21 for 16-bit operands); the 16-bit restoring divider,
// with the modular multiply folded into its quotient bits, sets each step's
// length. Modulus 0 or 1 skips the divider and goes straight to the finish.
// Reset sets the modulus to 256. The result strobe cannot be held off; busy
// is low in the strobe cycle, so the next word can be taken at that edge.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_inverse_unit import mi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_data_i,
  input  logic             start,
  input  logic [WIDTH-1:0] value_i,
  output logic             busy,
  output logic             done_o,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);

  localparam int W = WIDTH;

  op_e     op;
  status_t status;

  logic [W-1:0]     n_q;
  logic             done_q;
  logic [W-1:0]     inv_q;
  logic             noinv_q;
  logic [W-1:0]     rp_q, rc_q, pp_q, pc_q, t_q, rem_q, dvd_q, dsr_q;
  logic [CNT_W-1:0] cnt_q;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         qbit;
  logic [W-1:0] rem_step;
  logic [W:0]   t2, t2r, s;
  logic [W-1:0] addend, t_step;
  logic [W:0]   psum;
  logic [W-1:0] p_new;

  mi_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .op_o     (op),
    .busy     (busy)
  );

  // Divider step, modular multiply step, coefficient update
  always_comb begin
    shifted  = {rem_q, dvd_q[W-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr_q};
    qbit     = !diff[W+1];
    rem_step = qbit ? diff[W-1:0] : shifted[W-1:0];

    // t <- (2t + qbit*p_cur) mod n, Horner over quotient bits
    t2     = {t_q, 1'b0};
    t2r    = (t2 >= {1'b0, n_q}) ? t2 - {1'b0, n_q} : t2;
    addend = qbit ? pc_q : '0;
    s      = t2r + {1'b0, addend};
    t_step = (s >= {1'b0, n_q}) ? W'(s - {1'b0, n_q}) : s[W-1:0];

    // p_prev - q*p_cur, folded into [0, n)
    psum  = {1'b0, pp_q} + {1'b0, n_q} - {1'b0, t_q};
    p_new = (pp_q >= t_q) ? pp_q - t_q : psum[W-1:0];
  end

  assign status.cnt_nz = (cnt_q != '0);
  assign status.rc_le1 = (rc_q <= W'(1));
  assign status.n_lt2  = (n_q < W'(2));

  // Control state: modulus register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= MOD_RESET;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= cfg_data_i;
      end
      done_q <= (op == OP_FINISH);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        dvd_q <= value_i;
        dsr_q <= n_q;
        rem_q <= '0;
        rp_q  <= n_q;
        pp_q  <= '0;
        pc_q  <= W'(1);
        t_q   <= '0;
        cnt_q <= CNT_W'(W - 1);
      end
      OP_DIVSTEP: begin
        dvd_q <= {dvd_q[W-2:0], qbit};
        rem_q <= rem_step;
        t_q   <= t_step;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      OP_SETRC: begin
        rc_q <= rem_q;
      end
      OP_DIVSETUP: begin
        dvd_q <= rp_q;
        dsr_q <= rc_q;
        rem_q <= '0;
        t_q   <= '0;
        cnt_q <= CNT_W'(W - 1);
      end
      OP_UPDATE: begin
        rp_q <= rc_q;
        rc_q <= rem_q;
        pp_q <= pc_q;
        pc_q <= p_new;
      end
      OP_FINISH: begin
        if (n_q < W'(2)) begin
          inv_q   <= '0;
          noinv_q <= (n_q == '0);
        end else if (rc_q == W'(1)) begin
          inv_q   <= pc_q;
          noinv_q <= 1'b0;
        end else begin
          inv_q   <= '0;
          noinv_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o       = done_q;
  assign inverse_o    = inv_q;
  assign no_inverse_o = noinv_q;

  // Checks
  `MI_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `MI_ASSERT_IMP(a_done_idle, done_o, !busy, "sequencer not idle with result")
  `MI_ASSERT_IMP(a_noinv_zero, done_o && no_inverse_o, inverse_o == '0, "no-inverse with nonzero")
  `MI_ASSERT_IMP(a_inv_range, done_o && !no_inverse_o, inverse_o < n_q, "inverse not below modulus")

endmodule

// ----- design/mi_seq.sv -----
// ----------------------------------------------------------------------------
// mi_seq
// Microprogram sequencer: control store, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module mi_seq import mi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output op_e     op_o,
  output logic    busy
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;
  logic             take;

  // Control store
  function automatic uword_t rom_word(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: UPC_W'(0)};
    case (addr)
      UPC_W'(0): w = '{op: OP_LOAD,     cond: COND_IDLE,   target: UPC_W'(0)};
      UPC_W'(1): w = '{op: OP_NOP,      cond: COND_NLT2,   target: UPC_W'(7)};
      UPC_W'(2): w = '{op: OP_DIVSTEP,  cond: COND_CNT,    target: UPC_W'(2)};
      UPC_W'(3): w = '{op: OP_SETRC,    cond: COND_NEVER,  target: UPC_W'(0)};
      UPC_W'(4): w = '{op: OP_DIVSETUP, cond: COND_RCLE1,  target: UPC_W'(7)};
      UPC_W'(5): w = '{op: OP_DIVSTEP,  cond: COND_CNT,    target: UPC_W'(5)};
      UPC_W'(6): w = '{op: OP_UPDATE,   cond: COND_ALWAYS, target: UPC_W'(4)};
      UPC_W'(7): w = '{op: OP_FINISH,   cond: COND_ALWAYS, target: UPC_W'(0)};
      default:   w = '{op: OP_NOP,      cond: COND_ALWAYS, target: UPC_W'(0)};
    endcase
    return w;
  endfunction

  // Condition select and next step
  always_comb begin
    uw = rom_word(upc_q);
    case (uw.cond)
      COND_NEVER:  take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_IDLE:   take = !start;
      COND_CNT:    take = status_i.cnt_nz;
      COND_RCLE1:  take = status_i.rc_le1;
      COND_NLT2:   take = status_i.n_lt2;
      default:     take = 1'b1;
    endcase
    upc_d = take ? uw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign op_o = uw.op;
  assign busy = (upc_q != '0);

endmodule
